>>> sv/pwl_pkg.sv
`default_nettype none

package pwl_pkg;

  // Configuration register indexes.
  localparam logic [2:0] REG_OPEN_TICKS  = 3'd0;
  localparam logic [2:0] REG_HOLD_TICKS  = 3'd1;
  localparam logic [2:0] REG_CLOSE_TICKS = 3'd2;
  localparam logic [2:0] REG_ALARM_TICKS = 3'd3;
  localparam logic [2:0] REG_MAX_WRONG   = 3'd4;
  localparam logic [2:0] REG_TERMINATOR  = 3'd5;
  localparam logic [2:0] REG_OPEN_CODE   = 3'd6;
  localparam logic [2:0] REG_CHANGE_CODE = 3'd7;

  // Configuration reset values.
  localparam logic [7:0] RST_OPEN_TICKS  = 8'd2;
  localparam logic [7:0] RST_HOLD_TICKS  = 8'd1;
  localparam logic [7:0] RST_CLOSE_TICKS = 8'd2;
  localparam logic [7:0] RST_ALARM_TICKS = 8'd8;
  localparam logic [2:0] RST_MAX_WRONG   = 3'd3;
  localparam logic [7:0] RST_TERMINATOR  = 8'd61;
  localparam logic [7:0] RST_OPEN_CODE   = 8'd43;
  localparam logic [7:0] RST_CHANGE_CODE = 8'd45;

  // Input operation codes.
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_BYTE = 1'b1;

  // Motor drive codes.
  localparam logic [1:0] MOTOR_STOP  = 2'd0;
  localparam logic [1:0] MOTOR_OPEN  = 2'd1;
  localparam logic [1:0] MOTOR_CLOSE = 2'd2;

  // Match result reply values.
  localparam logic [7:0] REPLY_MATCH    = 8'd1;
  localparam logic [7:0] REPLY_MISMATCH = 8'd0;

  // One result item as held in the output buffer.
  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic [1:0] motor_drive;
    logic       alarm_on;
    logic [2:0] controller_phase;
  } pwl_result_t;

endpackage

`default_nettype wire

>>> sv/password_lock_controller.sv
`default_nettype none

// Password door-lock controller. Each input transfer is either a timer tick or a received
// link byte; each accepted item yields exactly one result, registered into the output register
// or, while the output stalls, the skid entry. One item is accepted every clock cycle while the
// skid entry is empty: the whole state update is a single pass of logic, and the password
// memory (MAX_LEN bytes, one write and one read port) is read one byte ahead at the next entry
// position so its registered data is ready when the next password byte arrives. A two-entry
// output buffer keeps the input side running while one result waits on a stalled output. The
// password memory has no reset and needs no clearing pass; only written positions are compared.
module password_lock_controller #(
  parameter int MAX_LEN = 16
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // Configuration write port
  input  wire logic       cfg_we,
  input  wire logic [2:0] cfg_index,
  input  wire logic [7:0] cfg_data,
  // Input channel
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic       in_operation,
  input  wire logic [7:0] in_rx_byte,
  // Result channel
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            out_tx_valid,
  output logic [7:0]      out_tx_byte,
  output logic [1:0]      out_motor_drive,
  output logic            out_alarm_on,
  output logic [2:0]      out_controller_phase
);

  import pwl_pkg::*;

  localparam int IDX_W = $clog2(MAX_LEN);
  localparam int LEN_W = $clog2(MAX_LEN + 1);
  localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(MAX_LEN - 1);

  typedef enum logic [2:0] {
    PH_FIRST  = 3'd0,
    PH_OPTION = 3'd1,
    PH_OPEN   = 3'd2,
    PH_CHANGE = 3'd3,
    PH_NEWPW  = 3'd4,
    PH_LOCK   = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    DOOR_IDLE    = 2'd0,
    DOOR_OPENING = 2'd1,
    DOOR_HOLDING = 2'd2,
    DOOR_CLOSING = 2'd3
  } door_t;

  // Configuration registers
  logic [7:0] open_ticks_r, hold_ticks_r, close_ticks_r, alarm_ticks_r;
  logic [2:0] max_wrong_r;
  logic [7:0] terminator_r, open_code_r, change_code_r;

  // Controller state
  phase_t           phase_r, phase_nxt;
  logic [LEN_W-1:0] stored_len_r, stored_len_nxt;
  logic [IDX_W-1:0] entry_idx_r, entry_idx_nxt;
  logic             mismatch_r, mismatch_nxt;
  logic [2:0]       wrong_cnt_r, wrong_cnt_nxt;
  door_t            door_r, door_nxt;
  logic [7:0]       door_cnt_r, door_cnt_nxt;
  logic [7:0]       alarm_cnt_r, alarm_cnt_nxt;

  // Output buffer
  logic        out_valid_r, out_valid_nxt;
  logic        skid_valid_r, skid_valid_nxt;
  pwl_result_t out_data_r, out_data_nxt;
  pwl_result_t skid_data_r, skid_data_nxt;
  pwl_result_t result;

  // Password memory
  logic [7:0]       pw_mem [MAX_LEN];
  logic [7:0]       mem_rdata_r;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;

  logic in_fire;
  logic out_fire;

  assign in_stall = skid_valid_r;
  assign in_fire  = in_valid && !in_stall;
  assign out_fire = out_valid_r && !out_stall;

  // Item processing: next state and the result of one accepted item.
  always_comb begin
    logic       term;
    logic       miss;
    logic       done;
    logic [7:0] limit;
    logic [7:0] dcnt;
    logic [7:0] acnt;
    logic [2:0] wcnt;

    phase_nxt      = phase_r;
    stored_len_nxt = stored_len_r;
    entry_idx_nxt  = entry_idx_r;
    mismatch_nxt   = mismatch_r;
    wrong_cnt_nxt  = wrong_cnt_r;
    door_nxt       = door_r;
    door_cnt_nxt   = door_cnt_r;
    alarm_cnt_nxt  = alarm_cnt_r;
    mem_we         = 1'b0;
    mem_waddr      = entry_idx_r;
    result         = '0;
    term           = (in_rx_byte == terminator_r);
    miss           = mismatch_r;
    done           = 1'b0;
    limit          = close_ticks_r;
    dcnt           = door_cnt_r + 8'd1;
    acnt           = alarm_cnt_r + 8'd1;
    wcnt           = wrong_cnt_r + 3'd1;

    // Password compare step, shared by open and change entry.
    if (term || entry_idx_r < LAST_POS) begin
      if (LEN_W'(entry_idx_r) >= stored_len_r || mem_rdata_r != in_rx_byte) begin
        miss = 1'b1;
      end
      if (term && (LEN_W'(entry_idx_r) + LEN_W'(1)) != stored_len_r) begin
        miss = 1'b1;
      end
      done = term;
    end

    if (in_fire) begin
      if (in_operation == OP_TICK) begin
        // Door timing runs in every phase.
        if (door_r != DOOR_IDLE) begin
          case (door_r)
            DOOR_OPENING: limit = open_ticks_r;
            DOOR_HOLDING: limit = hold_ticks_r;
            default:      limit = close_ticks_r;
          endcase
          door_cnt_nxt = dcnt;
          if (dcnt >= limit) begin
            door_cnt_nxt = '0;
            door_nxt     = (door_r == DOOR_CLOSING) ? DOOR_IDLE : door_t'(door_r + 2'd1);
          end
        end
        // Lockout countdown.
        if (phase_r == PH_LOCK) begin
          alarm_cnt_nxt = acnt;
          if (acnt >= alarm_ticks_r) begin
            alarm_cnt_nxt = '0;
            wrong_cnt_nxt = '0;
            phase_nxt     = PH_OPTION;
          end
        end
      end else begin
        unique case (phase_r)
          PH_FIRST, PH_NEWPW: begin
            if (term) begin
              mem_we         = 1'b1;
              stored_len_nxt = LEN_W'(entry_idx_r) + LEN_W'(1);
              entry_idx_nxt  = '0;
              phase_nxt      = PH_OPTION;
            end else if (entry_idx_r < LAST_POS) begin
              mem_we        = 1'b1;
              entry_idx_nxt = entry_idx_r + IDX_W'(1);
            end
          end
          PH_OPTION: begin
            if (in_rx_byte == open_code_r || in_rx_byte == change_code_r) begin
              result.tx_valid = 1'b1;
              result.tx_byte  = 8'(wrong_cnt_r);
              entry_idx_nxt   = '0;
              mismatch_nxt    = 1'b0;
              phase_nxt       = (in_rx_byte == open_code_r) ? PH_OPEN : PH_CHANGE;
            end
          end
          PH_OPEN, PH_CHANGE: begin
            mismatch_nxt = miss;
            if (term || entry_idx_r < LAST_POS) begin
              entry_idx_nxt = done ? '0 : entry_idx_r + IDX_W'(1);
            end
            if (done) begin
              if (phase_r == PH_CHANGE) begin
                result.tx_valid = 1'b1;
                result.tx_byte  = miss ? REPLY_MISMATCH : REPLY_MATCH;
              end
              if (!miss) begin
                wrong_cnt_nxt = '0;
                if (phase_r == PH_OPEN) begin
                  door_nxt     = DOOR_OPENING;
                  door_cnt_nxt = '0;
                  phase_nxt    = PH_OPTION;
                end else begin
                  phase_nxt = PH_NEWPW;
                end
              end else begin
                // Failed attempt: count it and lock out at the limit.
                wrong_cnt_nxt = wcnt;
                if (wcnt >= max_wrong_r) begin
                  phase_nxt     = PH_LOCK;
                  alarm_cnt_nxt = '0;
                end else begin
                  phase_nxt = PH_OPTION;
                end
              end
            end
          end
          default: begin
            // Link bytes are dropped during lockout.
          end
        endcase
      end
    end

    result.motor_drive      = (door_nxt == DOOR_OPENING) ? MOTOR_OPEN :
                              (door_nxt == DOOR_CLOSING) ? MOTOR_CLOSE : MOTOR_STOP;
    result.alarm_on         = (phase_nxt == PH_LOCK);
    result.controller_phase = phase_nxt;
  end

  // Output buffer: the output register, backed by one skid entry.
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (out_fire || !out_valid_r) begin
      out_valid_nxt  = skid_valid_r || in_fire;
      out_data_nxt   = skid_valid_r ? skid_data_r : result;
      skid_valid_nxt = skid_valid_r && in_fire;
      if (skid_valid_r && in_fire) begin
        skid_data_nxt = result;
      end
    end else if (in_fire) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = result;
    end
  end

  // State, configuration and output registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_ticks_r  <= RST_OPEN_TICKS;
      hold_ticks_r  <= RST_HOLD_TICKS;
      close_ticks_r <= RST_CLOSE_TICKS;
      alarm_ticks_r <= RST_ALARM_TICKS;
      max_wrong_r   <= RST_MAX_WRONG;
      terminator_r  <= RST_TERMINATOR;
      open_code_r   <= RST_OPEN_CODE;
      change_code_r <= RST_CHANGE_CODE;
      phase_r       <= PH_FIRST;
      stored_len_r  <= '0;
      entry_idx_r   <= '0;
      mismatch_r    <= 1'b0;
      wrong_cnt_r   <= '0;
      door_r        <= DOOR_IDLE;
      door_cnt_r    <= '0;
      alarm_cnt_r   <= '0;
      out_valid_r   <= 1'b0;
      skid_valid_r  <= 1'b0;
      out_data_r    <= '0;
      skid_data_r   <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_OPEN_TICKS:  open_ticks_r  <= cfg_data;
          REG_HOLD_TICKS:  hold_ticks_r  <= cfg_data;
          REG_CLOSE_TICKS: close_ticks_r <= cfg_data;
          REG_ALARM_TICKS: alarm_ticks_r <= cfg_data;
          REG_MAX_WRONG:   max_wrong_r   <= cfg_data[2:0];
          REG_TERMINATOR:  terminator_r  <= cfg_data;
          REG_OPEN_CODE:   open_code_r   <= cfg_data;
          REG_CHANGE_CODE: change_code_r <= cfg_data;
        endcase
      end
      phase_r      <= phase_nxt;
      stored_len_r <= stored_len_nxt;
      entry_idx_r  <= entry_idx_nxt;
      mismatch_r   <= mismatch_nxt;
      wrong_cnt_r  <= wrong_cnt_nxt;
      door_r       <= door_nxt;
      door_cnt_r   <= door_cnt_nxt;
      alarm_cnt_r  <= alarm_cnt_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
      out_data_r   <= out_data_nxt;
      skid_data_r  <= skid_data_nxt;
    end
  end

  // Password memory; the read runs one position ahead of the entry.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      pw_mem[mem_waddr] <= in_rx_byte;
    end
    mem_rdata_r <= pw_mem[entry_idx_nxt];
  end

  assign out_valid            = out_valid_r;
  assign out_tx_valid         = out_data_r.tx_valid;
  assign out_tx_byte          = out_data_r.tx_byte;
  assign out_motor_drive      = out_data_r.motor_drive;
  assign out_alarm_on         = out_data_r.alarm_on;
  assign out_controller_phase = out_data_r.controller_phase;

`ifndef SYNTHESIS
  // The skid entry only fills behind a held output register.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry valid while output register empty");

  // The alarm indication tracks the lockout phase in every result.
  a_alarm_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_alarm_on == (out_controller_phase == PH_LOCK)))
    else $error("alarm output disagrees with controller phase");

  // The entry position never passes the last memory slot.
  a_entry_range: assert property (@(posedge clk) disable iff (!rst_n)
    entry_idx_r <= LAST_POS)
    else $error("entry position beyond password memory");

  // A transfer taken while the output holds lands in the skid entry.
  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && out_valid_r && out_stall) |=> skid_valid_r)
    else $error("accepted item lost behind stalled output");
`endif

endmodule

`default_nettype wire

>>> verif/lock_response_checker.sv
`timescale 1ns / 100ps

// Watches the configuration port and both channels of the door-lock controller.
// Each accepted input transfer is run through a local model of the controller.
// Each accepted output transfer is compared with the oldest predicted response.
module lock_response_checker #(
  parameter int MAX_LEN = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [2:0]              cfg_index,
  input  logic [7:0]              cfg_data,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic                    in_operation,
  input  logic [7:0]              in_rx_byte,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic                    out_tx_valid,
  input  logic [7:0]              out_tx_byte,
  input  logic [1:0]              out_motor_drive,
  input  logic                    out_alarm_on,
  input  logic [2:0]              out_controller_phase,
  output int                      error_count,
  output int                      pending_count,
  output logic                    awaiting_password,
  output logic                    awaiting_option,
  output logic                    awaiting_entry,
  output logic                    locked_out,
  output logic [MAX_LEN-1:0][7:0] stored_bytes,
  output int                      stored_len
);

  import pwl_pkg::*;

  localparam int LAST_POS = MAX_LEN - 1;

  typedef enum logic [2:0] {
    CTL_FIRST,
    CTL_OPTION,
    CTL_OPEN,
    CTL_CHANGE,
    CTL_NEWPW,
    CTL_LOCK
  } ctl_phase_t;

  typedef enum logic [1:0] {
    DOOR_IDLE,
    DOOR_OPENING,
    DOOR_HOLDING,
    DOOR_CLOSING
  } door_phase_t;

  // Local copy of the configuration registers.
  logic [7:0] open_ticks;
  logic [7:0] hold_ticks;
  logic [7:0] close_ticks;
  logic [7:0] alarm_ticks;
  logic [2:0] max_wrong;
  logic [7:0] terminator;
  logic [7:0] open_code;
  logic [7:0] change_code;

  // Local copy of the controller state.
  ctl_phase_t             phase_q;
  logic [MAX_LEN-1:0][7:0] pw_mem;
  int                     pw_len;
  int                     entry_pos;
  logic                   mismatch;
  logic [2:0]             wrong_cnt;
  door_phase_t            door_q;
  logic [7:0]             door_cnt;
  logic [7:0]             alarm_cnt;

  pwl_result_t expected_responses[$];

  assign awaiting_password = (phase_q == CTL_FIRST) || (phase_q == CTL_NEWPW);
  assign awaiting_option   = (phase_q == CTL_OPTION);
  assign awaiting_entry    = (phase_q == CTL_OPEN) || (phase_q == CTL_CHANGE);
  assign locked_out        = (phase_q == CTL_LOCK);
  assign stored_bytes      = pw_mem;
  assign stored_len        = pw_len;

  function automatic void reset_model();
    open_ticks  = RST_OPEN_TICKS;
    hold_ticks  = RST_HOLD_TICKS;
    close_ticks = RST_CLOSE_TICKS;
    alarm_ticks = RST_ALARM_TICKS;
    max_wrong   = RST_MAX_WRONG;
    terminator  = RST_TERMINATOR;
    open_code   = RST_OPEN_CODE;
    change_code = RST_CHANGE_CODE;
    phase_q     = CTL_FIRST;
    pw_mem      = '0;
    pw_len      = 0;
    entry_pos   = 0;
    mismatch    = 1'b0;
    wrong_cnt   = 3'd0;
    door_q      = DOOR_IDLE;
    door_cnt    = 8'd0;
    alarm_cnt   = 8'd0;
  endfunction

  function automatic void write_register(input logic [2:0] idx, input logic [7:0] val);
    case (idx)
      REG_OPEN_TICKS:  open_ticks  = val;
      REG_HOLD_TICKS:  hold_ticks  = val;
      REG_CLOSE_TICKS: close_ticks = val;
      REG_ALARM_TICKS: alarm_ticks = val;
      REG_MAX_WRONG:   max_wrong   = val[2:0];
      REG_TERMINATOR:  terminator  = val;
      REG_OPEN_CODE:   open_code   = val;
      REG_CHANGE_CODE: change_code = val;
      default: ;
    endcase
  endfunction

  // Records one password byte; bytes past the last body slot are dropped, and the
  // terminator lands right after the kept bytes. Returns 1 on the terminator.
  function automatic logic take_password_byte(input logic [7:0] b);
    int pos;
    pos = (entry_pos > LAST_POS) ? LAST_POS : entry_pos;
    if (b == terminator) begin
      pw_mem[pos] = b;
      pw_len      = pos + 1;
      entry_pos   = 0;
      return 1'b1;
    end
    if (pos < LAST_POS) begin
      pw_mem[pos] = b;
      entry_pos   = pos + 1;
    end
    return 1'b0;
  endfunction

  // Compares one entered byte against the stored password. Returns 1 on the terminator.
  function automatic logic check_entry_byte(input logic [7:0] b);
    int   pos;
    logic term;
    term = (b == terminator);
    pos  = (entry_pos > LAST_POS) ? LAST_POS : entry_pos;
    if (term || pos < LAST_POS) begin
      if (pos >= pw_len || pw_mem[pos] != b) begin
        mismatch = 1'b1;
      end
      if (term) begin
        if (pos + 1 != pw_len) begin
          mismatch = 1'b1;
        end
        entry_pos = 0;
        return 1'b1;
      end
      entry_pos = pos + 1;
    end
    return 1'b0;
  endfunction

  // A failed attempt raises the count and may start the lockout.
  function automatic void count_failure();
    wrong_cnt = wrong_cnt + 3'd1;
    if (wrong_cnt >= max_wrong) begin
      phase_q   = CTL_LOCK;
      alarm_cnt = 8'd0;
    end else begin
      phase_q = CTL_OPTION;
    end
  endfunction

  // Steps the door sequence by one tick.
  function automatic void advance_door();
    logic [7:0] limit;
    if (door_q == DOOR_IDLE) begin
      return;
    end
    case (door_q)
      DOOR_OPENING: limit = open_ticks;
      DOOR_HOLDING: limit = hold_ticks;
      default:      limit = close_ticks;
    endcase
    door_cnt = door_cnt + 8'd1;
    if (door_cnt >= limit) begin
      door_cnt = 8'd0;
      case (door_q)
        DOOR_OPENING: door_q = DOOR_HOLDING;
        DOOR_HOLDING: door_q = DOOR_CLOSING;
        default:      door_q = DOOR_IDLE;
      endcase
    end
  endfunction

  // Applies one input item to the model and returns the response it produces.
  function automatic pwl_result_t next_lock_response(input logic op, input logic [7:0] b);
    pwl_result_t r;
    r = '0;
    if (op == OP_TICK) begin
      advance_door();
      if (phase_q == CTL_LOCK) begin
        alarm_cnt = alarm_cnt + 8'd1;
        if (alarm_cnt >= alarm_ticks) begin
          alarm_cnt = 8'd0;
          wrong_cnt = 3'd0;
          phase_q   = CTL_OPTION;
        end
      end
    end else begin
      case (phase_q)
        CTL_FIRST, CTL_NEWPW: begin
          if (take_password_byte(b)) begin
            phase_q = CTL_OPTION;
          end
        end
        CTL_OPTION: begin
          if (b == open_code || b == change_code) begin
            r.tx_valid = 1'b1;
            r.tx_byte  = {5'd0, wrong_cnt};
            entry_pos  = 0;
            mismatch   = 1'b0;
            phase_q    = (b == open_code) ? CTL_OPEN : CTL_CHANGE;
          end
        end
        CTL_OPEN: begin
          if (check_entry_byte(b)) begin
            if (!mismatch) begin
              wrong_cnt = 3'd0;
              door_q    = DOOR_OPENING;
              door_cnt  = 8'd0;
              phase_q   = CTL_OPTION;
            end else begin
              count_failure();
            end
          end
        end
        CTL_CHANGE: begin
          if (check_entry_byte(b)) begin
            r.tx_valid = 1'b1;
            r.tx_byte  = mismatch ? REPLY_MISMATCH : REPLY_MATCH;
            if (!mismatch) begin
              wrong_cnt = 3'd0;
              entry_pos = 0;
              phase_q   = CTL_NEWPW;
            end else begin
              count_failure();
            end
          end
        end
        default: ;
      endcase
    end
    case (door_q)
      DOOR_OPENING: r.motor_drive = MOTOR_OPEN;
      DOOR_CLOSING: r.motor_drive = MOTOR_CLOSE;
      default:      r.motor_drive = MOTOR_STOP;
    endcase
    r.alarm_on         = (phase_q == CTL_LOCK);
    r.controller_phase = phase_q;
    return r;
  endfunction

  task automatic report_error(input string what, input pwl_result_t want,
                              input pwl_result_t seen);
    if (error_count < 10) begin
      $display("%0t: %s: expected tx %0b/%0d motor %0d alarm %0b phase %0d",
               $realtime, what, want.tx_valid, want.tx_byte, want.motor_drive,
               want.alarm_on, want.controller_phase);
      $display("%0t: %s: got tx %0b/%0d motor %0d alarm %0b phase %0d",
               $realtime, what, seen.tx_valid, seen.tx_byte, seen.motor_drive,
               seen.alarm_on, seen.controller_phase);
    end
    error_count++;
  endtask

  initial error_count = 0;

  // Output transfers are checked before the input transfer of the same edge is
  // predicted, since a response never leaves in the cycle its item is taken.
  always @(posedge clk) begin : scoreboard
    pwl_result_t seen;
    pwl_result_t want;
    if (!rst_n) begin
      reset_model();
      expected_responses.delete();
    end else begin
      if (cfg_we) begin
        write_register(cfg_index, cfg_data);
      end
      if (out_valid && !out_stall) begin
        seen = {out_tx_valid, out_tx_byte, out_motor_drive, out_alarm_on, out_controller_phase};
        if (expected_responses.size() == 0) begin
          report_error("unexpected response", '0, seen);
        end else begin
          want = expected_responses.pop_front();
          if (seen.tx_valid !== want.tx_valid || seen.tx_byte !== want.tx_byte ||
              seen.motor_drive !== want.motor_drive || seen.alarm_on !== want.alarm_on ||
              seen.controller_phase !== want.controller_phase) begin
            report_error("response mismatch", want, seen);
          end
        end
      end
      if (in_valid && !in_stall) begin
        expected_responses.push_back(next_lock_response(in_operation, in_rx_byte));
      end
    end
    pending_count = expected_responses.size();
  end

endmodule

>>> verif/tb_password_lock_controller.sv
`timescale 1ns / 100ps

module tb_password_lock_controller;
  import pwl_pkg::*;

  localparam int MAX_LEN         = 16;
  localparam int HALF_PERIOD     = 6;
  localparam int CYCLE_LIMIT     = 600000;
  localparam int HOLD_OFF_CYCLES = 250;
  localparam int PHASE_ITEMS     = 385;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       in_operation = OP_TICK;
  logic [7:0] in_rx_byte = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_tx_valid;
  logic [7:0] out_tx_byte;
  logic [1:0] out_motor_drive;
  logic       out_alarm_on;
  logic [2:0] out_controller_phase;

  int                      error_count;
  int                      pending_count;
  logic                    awaiting_password;
  logic                    awaiting_option;
  logic                    awaiting_entry;
  logic                    locked_out;
  logic [MAX_LEN-1:0][7:0] stored_bytes;
  int                      stored_len;

  // Register values as last written, used to shape the stimulus.
  logic [7:0] cur_term   = RST_TERMINATOR;
  logic [7:0] cur_open   = RST_OPEN_CODE;
  logic [7:0] cur_change = RST_CHANGE_CODE;

  int   items_sent = 0;
  int   cycle_count = 0;
  logic sender_steady = 1'b0;
  logic hold_req = 1'b0;

  password_lock_controller #(.MAX_LEN(MAX_LEN)) dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_operation         (in_operation),
    .in_rx_byte           (in_rx_byte),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_tx_valid         (out_tx_valid),
    .out_tx_byte          (out_tx_byte),
    .out_motor_drive      (out_motor_drive),
    .out_alarm_on         (out_alarm_on),
    .out_controller_phase (out_controller_phase)
  );

  lock_response_checker #(.MAX_LEN(MAX_LEN)) chk (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_operation         (in_operation),
    .in_rx_byte           (in_rx_byte),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_tx_valid         (out_tx_valid),
    .out_tx_byte          (out_tx_byte),
    .out_motor_drive      (out_motor_drive),
    .out_alarm_on         (out_alarm_on),
    .out_controller_phase (out_controller_phase),
    .error_count          (error_count),
    .pending_count        (pending_count),
    .awaiting_password    (awaiting_password),
    .awaiting_option      (awaiting_option),
    .awaiting_entry       (awaiting_entry),
    .locked_out           (locked_out),
    .stored_bytes         (stored_bytes),
    .stored_len           (stored_len)
  );

  // Clock generation.
  initial begin
    forever #(HALF_PERIOD) clk = ~clk;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Mostly short idle gaps, now and then a long one.
  function automatic int random_gap();
    int r;
    r = $urandom_range(99, 0);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic logic [7:0] random_byte();
    return 8'($urandom_range(255, 0));
  endfunction

  function automatic logic [7:0] random_body_byte();
    logic [7:0] b;
    do b = random_byte(); while (b == cur_term);
    return b;
  endfunction

  // Result side: random stalls, plus one long hold-off on request.
  initial begin : receiver
    int stall_len;
    int run_len;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else begin
        stall_len = random_gap();
        if (stall_len > 0) begin
          out_stall <= 1'b1;
          repeat (stall_len) @(negedge clk);
          out_stall <= 1'b0;
        end
        run_len = ($urandom_range(9, 0) == 0) ? $urandom_range(200, 40) : $urandom_range(6, 1);
        repeat (run_len - 1) @(negedge clk);
      end
    end
  end

  // Offers one item and returns at the falling edge after its transfer.
  task automatic send_item(input logic op, input logic [7:0] b);
    int gap;
    gap = sender_steady ? 0 : random_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_rx_byte   <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  // A link byte, sometimes preceded by a stray timer tick.
  task automatic send_link_byte(input logic [7:0] b);
    if ($urandom_range(9, 0) == 0) begin
      send_item(OP_TICK, random_byte());
    end
    send_item(OP_BYTE, b);
  endtask

  task automatic send_body(input logic [7:0] body[$]);
    foreach (body[i]) begin
      send_link_byte(body[i]);
    end
    send_link_byte(cur_term);
  endtask

  // A new password: mostly short, sometimes longer than the store can keep.
  task automatic send_password();
    logic [7:0] body[$];
    int         len;
    int         r;
    r = $urandom_range(99, 0);
    if (r < 75) len = $urandom_range(6, 0);
    else if (r < 93) len = $urandom_range(MAX_LEN - 2, 7);
    else len = $urandom_range(MAX_LEN + 8, MAX_LEN - 1);
    repeat (len) body.push_back(random_body_byte());
    send_body(body);
  endtask

  // An entered password, built from the stored one. A correct entry against a
  // full-length store may carry extra bytes that the block drops.
  task automatic send_entry(input logic correct);
    logic [7:0] body[$];
    logic [7:0] nb;
    int         idx;
    int         kind;
    for (int i = 0; i < stored_len - 1; i++) body.push_back(stored_bytes[i]);
    if (correct) begin
      if (stored_len == MAX_LEN && $urandom_range(1, 0) == 1) begin
        repeat ($urandom_range(6, 1)) body.push_back(random_body_byte());
      end
    end else begin
      kind = $urandom_range(3, 0);
      if (kind == 2 && body.size() < MAX_LEN - 1) begin
        body.push_back(random_body_byte());
      end else if (kind == 1 && body.size() > 0) begin
        void'(body.pop_back());
      end else if (kind == 3) begin
        body.delete();
        repeat ($urandom_range(MAX_LEN + 2, 0)) body.push_back(random_body_byte());
      end else if (body.size() > 0) begin
        idx = $urandom_range(body.size() - 1, 0);
        do nb = random_body_byte(); while (nb == body[idx]);
        body[idx] = nb;
      end else begin
        body.push_back(random_body_byte());
      end
    end
    send_body(body);
  endtask

  // One well-formed step of a session, chosen from the predicted controller phase.
  task automatic run_sequence();
    logic [7:0] b;
    int         r;
    sender_steady = ($urandom_range(4, 0) == 0);
    if (locked_out) begin
      while (locked_out) begin
        if ($urandom_range(6, 0) == 0) send_item(OP_BYTE, random_byte());
        else send_item(OP_TICK, random_byte());
      end
    end else if (awaiting_password) begin
      send_password();
    end else if (awaiting_entry) begin
      send_entry($urandom_range(99, 0) < 70);
    end else begin
      r = $urandom_range(99, 0);
      if (r < 40) begin
        send_link_byte(cur_open);
      end else if (r < 75) begin
        send_link_byte(cur_change);
      end else if (r < 85) begin
        do b = random_byte(); while (b == cur_open || b == cur_change);
        send_link_byte(b);
      end else begin
        repeat ($urandom_range(8, 1)) send_item(OP_TICK, random_byte());
      end
    end
  endtask

  task automatic run_random(input int budget);
    int stop_at;
    stop_at = items_sent + budget;
    while (items_sent < stop_at) run_sequence();
  endtask

  // Leaves the controller waiting for a new password, so that a new terminator
  // can be set before the next password is stored.
  task automatic steer_to_new_password();
    sender_steady = 1'b0;
    while (!awaiting_password) begin
      if (locked_out) send_item(OP_TICK, random_byte());
      else if (awaiting_entry) send_entry(1'b1);
      else send_item(OP_BYTE, cur_change);
    end
  endtask

  // Sender pause until every predicted response has been seen.
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_count != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
  endtask

  task automatic apply_settings(input logic [7:0] open_t, input logic [7:0] hold_t,
                                input logic [7:0] close_t, input logic [7:0] alarm_t,
                                input logic [2:0] wrong_lim, input logic [7:0] term,
                                input logic [7:0] open_c, input logic [7:0] change_c);
    write_reg(REG_OPEN_TICKS, open_t);
    write_reg(REG_HOLD_TICKS, hold_t);
    write_reg(REG_CLOSE_TICKS, close_t);
    write_reg(REG_ALARM_TICKS, alarm_t);
    write_reg(REG_MAX_WRONG, {5'd0, wrong_lim});
    write_reg(REG_TERMINATOR, term);
    write_reg(REG_OPEN_CODE, open_c);
    write_reg(REG_CHANGE_CODE, change_c);
    cfg_we     <= 1'b0;
    cur_term   = term;
    cur_open   = open_c;
    cur_change = change_c;
  endtask

  initial begin : stimulus
    logic [7:0] term;
    logic [7:0] code_a;
    logic [7:0] code_b;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed session at reset settings: first password with extreme bytes,
    // open and door run, unknown option, failed and successful change, a
    // terminator-only password, and an open request while the door still runs.
    send_item(OP_BYTE, 8'h00);
    send_item(OP_BYTE, 8'hff);
    send_item(OP_BYTE, cur_term);
    send_item(OP_BYTE, cur_open);
    send_item(OP_BYTE, 8'h00);
    send_item(OP_BYTE, 8'hff);
    send_item(OP_BYTE, cur_term);
    send_item(OP_TICK, 8'hff);
    send_item(OP_TICK, 8'h00);
    send_item(OP_BYTE, 8'h55);
    send_item(OP_BYTE, cur_change);
    send_item(OP_BYTE, 8'h00);
    send_item(OP_BYTE, cur_term);
    send_item(OP_BYTE, cur_change);
    send_item(OP_BYTE, 8'h00);
    send_item(OP_BYTE, 8'hff);
    send_item(OP_BYTE, cur_term);
    send_item(OP_BYTE, cur_term);
    send_item(OP_BYTE, cur_open);
    send_item(OP_BYTE, cur_term);
    repeat (3) send_item(OP_TICK, random_byte());

    // Reset settings, with one long hold-off on the result side.
    run_random(150);
    hold_req = 1'b1;
    run_random(PHASE_ITEMS - 150);
    steer_to_new_password();
    drain();

    // Smallest settings: every failure locks out for a single tick.
    apply_settings(8'd1, 8'd1, 8'd1, 8'd1, 3'd1, 8'd0, 8'd255, 8'd1);
    run_random(PHASE_ITEMS);
    steer_to_new_password();
    drain();

    // Largest settings.
    apply_settings(8'd255, 8'd255, 8'd255, 8'd255, 3'd7, 8'd255, 8'd0, 8'd254);
    run_random(PHASE_ITEMS);
    steer_to_new_password();
    drain();

    // Random settings with distinct option codes.
    code_a = random_byte();
    do code_b = random_byte(); while (code_b == code_a);
    apply_settings(8'($urandom_range(6, 1)), 8'($urandom_range(6, 1)),
                   8'($urandom_range(6, 1)), 8'($urandom_range(12, 1)),
                   3'($urandom_range(7, 1)), random_byte(), code_a, code_b);
    run_random(PHASE_ITEMS);
    steer_to_new_password();
    drain();

    // Both option codes equal: the open request wins.
    term = random_byte();
    do code_a = random_byte(); while (code_a == term);
    apply_settings(8'($urandom_range(4, 1)), 8'($urandom_range(4, 1)),
                   8'($urandom_range(4, 1)), 8'($urandom_range(6, 1)),
                   3'($urandom_range(7, 2)), term, code_a, code_a);
    run_random(PHASE_ITEMS);
    drain();

    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/pwl_pkg.sv
sv/password_lock_controller.sv
verif/lock_response_checker.sv
verif/tb_password_lock_controller.sv
